### rtl/midpoint_line_rasterizer_core_macros.svh
// Assertion macros for the midpoint line rasterizer.
// Expects the including scope to have signals named clock and reset.
`ifndef MIDPOINT_LINE_RASTERIZER_CORE_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_CORE_MACROS_SVH

// Check a property outside of reset.
`define MLR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define MLR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/mlr_pkg.sv
// Shared types, constants and helpers for the midpoint line rasterizer.
// No dependencies; used by every module of the block.
package mlr_pkg;

   localparam int COORD_BITS_DEF = 6;
   localparam int QUEUE_DEPTH    = 2;

   // Register indexes of the configuration port
   typedef enum logic [0:0] {
      CSR_COL_LIMIT = 1'b0,
      CSR_ROW_LIMIT = 1'b1
   } mlr_csr_type;

   typedef enum logic [0:0] {
      BACK_IDLE = 1'b0,
      BACK_WALK = 1'b1
   } mlr_back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mlr_qstat_type;

   // Width of one classified segment: u_start, v_start, u_end, dx, dy, steep, mirror
   function automatic int entry_bits(input int coord_bits);
      return 5 * coord_bits + 2;
   endfunction

endpackage

### rtl/midpoint_line_rasterizer_core.sv
// Top level of the midpoint line rasterizer: classifier, queue, walker, limit registers.
// Depends on mlr_pkg, mlr_front, mlr_queue, mlr_back and the assertion macro header.
`include "midpoint_line_rasterizer_core_macros.svh"

// Scan-converts one line segment per request into its midpoint (Bresenham) pixels, all
// octants. A request is taken at a clock edge with start high and busy low. The segment is
// ordered and classified into a register, waits in a two-entry queue, and the walker then emits
// max(|dx|, |dy|) + 1 pixels, up to 2^COORD_BITS (64 at the default), one per cycle, from the
// low end of the major axis upward. A request that finds the block empty passes the classifier
// register, the queue and the walker state before its first pixel is registered at the output,
// and back-to-back segments stream with no gap. Each pixel is shown for
// exactly one cycle with rsp_valid high; there is no back-pressure, so capture it then.
// rsp_visible marks pixels strictly inside the column and row limits; rsp_last marks the
// final pixel of a segment. busy rises only when the queue and the classifier stage are full.
// Write the limits through csr_* only while no segment is in flight.
module midpoint_line_rasterizer_core #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   input  logic                  csr_write_enable,
   input  logic [0:0]            csr_index,
   input  logic [COORD_BITS:0]   csr_data,
   output logic                  rsp_valid,
   output logic [COORD_BITS-1:0] rsp_pix_x,
   output logic [COORD_BITS-1:0] rsp_pix_y,
   output logic                  rsp_visible,
   output logic                  rsp_last
);
   import mlr_pkg::*;

   localparam int EB = entry_bits(COORD_BITS);

   logic [COORD_BITS:0] col_limit_ff, col_limit_in, row_limit_ff, row_limit_in;
   mlr_qstat_type       q_stat;
   logic                q_push, q_pop, walking;
   logic [EB-1:0]       q_push_data, q_pop_data;
   logic                take_idle;

   // Limit registers: default to the full tile
   always_comb begin
      col_limit_in = col_limit_ff;
      row_limit_in = row_limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COL_LIMIT: col_limit_in = csr_data;
            CSR_ROW_LIMIT: row_limit_in = csr_data;
            default: begin
               col_limit_in = col_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_limit_ff <= {1'b1, {COORD_BITS{1'b0}}};
         row_limit_ff <= {1'b1, {COORD_BITS{1'b0}}};
      end else begin
         col_limit_ff <= col_limit_in;
         row_limit_ff <= row_limit_in;
      end
   end

   // Classify the request and hold it until the queue has room
   mlr_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_data      (q_push_data)
   );

   // Decouple classification from the pixel walk
   mlr_queue #(.ENTRY_BITS(EB)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .stat      (q_stat)
   );

   // Walk the segment and clip each pixel against the current limits
   mlr_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_stat      (q_stat),
      .q_data      (q_pop_data),
      .q_pop       (q_pop),
      .col_limit   (col_limit_ff),
      .row_limit   (row_limit_ff),
      .busy_walk   (walking),
      .rsp_valid   (rsp_valid),
      .rsp_pix_x   (rsp_pix_x),
      .rsp_pix_y   (rsp_pix_y),
      .rsp_visible (rsp_visible),
      .rsp_last    (rsp_last)
   );

   // A request taken while every stage is empty
   assign take_idle = start && !busy && !walking && q_stat.empty && !q_push;

   // No pixel strobe right after reset
   `MLR_ASSERT_ALWAYS(a_no_rsp_after_reset, $fell(reset) |-> !rsp_valid, "pixel right after reset")
   // Never push into a full queue
   `MLR_ASSERT(a_no_overflow, q_push |-> !q_stat.full, "queue overflow")
   // Never pop an empty queue
   `MLR_ASSERT(a_no_underflow, q_pop |-> !q_stat.empty, "queue underflow")
   // A request into an empty block reaches rsp_valid through the classifier, queue and walker
   `MLR_ASSERT(a_first_pixel, take_idle |-> ##4 rsp_valid, "first pixel late")

endmodule

### rtl/mlr_front.sv
// Front end: accepts a segment request and classifies it (order, steep, mirror).
// Depends on mlr_pkg; feeds mlr_queue.
module mlr_front #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   output logic                                         busy,
   input  logic [COORD_BITS-1:0]                        req_x_start,
   input  logic [COORD_BITS-1:0]                        req_y_start,
   input  logic [COORD_BITS-1:0]                        req_x_end,
   input  logic [COORD_BITS-1:0]                        req_y_end,
   input  mlr_pkg::mlr_qstat_type                       q_stat,
   output logic                                         q_push,
   output logic [mlr_pkg::entry_bits(COORD_BITS)-1:0]   q_data
);
   import mlr_pkg::*;

   localparam int C = COORD_BITS;

   typedef struct packed {
      logic [C-1:0] u_start;
      logic [C-1:0] v_start;
      logic [C-1:0] u_end;
      logic [C-1:0] dx;
      logic [C-1:0] dy;
      logic         steep;
      logic         mirror;
   } entry_type;

   logic         valid_ff, valid_in;
   entry_type    entry_ff, entry_in;
   logic         take;
   logic         swap, steep, lo_first, mirror;
   logic [C-1:0] ax, ay, bx, by, adx, ady;
   logic [C-1:0] u_start, v_start, u_end, v_end, dx;

   // Order by column, then swap axes for steep segments and order by row
   always_comb begin
      swap = req_x_start > req_x_end;
      ax   = swap ? req_x_end   : req_x_start;
      ay   = swap ? req_y_end   : req_y_start;
      bx   = swap ? req_x_start : req_x_end;
      by   = swap ? req_y_start : req_y_end;
      adx  = bx - ax;
      ady  = (by >= ay) ? (by - ay) : (ay - by);
      steep    = ady > adx;
      lo_first = ay <= by;
      if (steep) begin
         u_start = lo_first ? ay : by;
         v_start = lo_first ? ax : bx;
         u_end   = lo_first ? by : ay;
         v_end   = lo_first ? bx : ax;
      end else begin
         u_start = ax;
         v_start = ay;
         u_end   = bx;
         v_end   = by;
      end
      dx     = u_end - u_start;
      mirror = v_end < v_start;
      entry_in.u_start = u_start;
      entry_in.v_start = v_start;
      entry_in.u_end   = u_end;
      entry_in.dx      = dx;
      entry_in.dy      = mirror ? (v_start - v_end) : (v_end - v_start);
      entry_in.steep   = steep;
      entry_in.mirror  = mirror;
   end

   assign q_push   = valid_ff && !q_stat.full;
   assign busy     = valid_ff && q_stat.full;
   assign take     = start && !busy;
   assign valid_in = take || (valid_ff && q_stat.full);
   assign q_data   = entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff <= entry_in;
      end
   end

endmodule

### rtl/mlr_queue.sv
// Short request queue between the classifier and the line walker.
// Depends on mlr_pkg for its depth and status type.
module mlr_queue #(
   parameter int ENTRY_BITS = mlr_pkg::entry_bits(mlr_pkg::COORD_BITS_DEF)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [ENTRY_BITS-1:0]         push_data,
   input  logic                          pop,
   output logic [ENTRY_BITS-1:0]         pop_data,
   output mlr_pkg::mlr_qstat_type        stat
);
   import mlr_pkg::*;

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [ENTRY_BITS-1:0] mem [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + COUNT_BITS'(push) - COUNT_BITS'(pop);
      stat.full  = count_ff == COUNT_BITS'(QUEUE_DEPTH);
      stat.empty = count_ff == '0;
   end

   assign pop_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/mlr_back.sv
// Back end: walks one classified segment, one pixel per cycle, and clips it.
// Depends on mlr_pkg; reads from mlr_queue.
module mlr_back #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  mlr_pkg::mlr_qstat_type                       q_stat,
   input  logic [mlr_pkg::entry_bits(COORD_BITS)-1:0]   q_data,
   output logic                                         q_pop,
   input  logic [COORD_BITS:0]                          col_limit,
   input  logic [COORD_BITS:0]                          row_limit,
   output logic                                         busy_walk,
   output logic                                         rsp_valid,
   output logic [COORD_BITS-1:0]                        rsp_pix_x,
   output logic [COORD_BITS-1:0]                        rsp_pix_y,
   output logic                                         rsp_visible,
   output logic                                         rsp_last
);
   import mlr_pkg::*;

   localparam int C = COORD_BITS;
   localparam int D = C + 3;

   typedef struct packed {
      logic [C-1:0] u_start;
      logic [C-1:0] v_start;
      logic [C-1:0] u_end;
      logic [C-1:0] dx;
      logic [C-1:0] dy;
      logic         steep;
      logic         mirror;
   } entry_type;

   mlr_back_state_type state_ff, state_in;
   entry_type          entry;
   logic [C-1:0]       u_ff, u_in, minor_ff, minor_in, end_ff, end_in;
   logic signed [D-1:0] d_ff, d_in, inc_e_ff, inc_e_in, inc_ne_ff, inc_ne_in;
   logic               steep_ff, steep_in, mirror_ff, mirror_in;
   logic               fin, load;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [C-1:0]       pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic               visible_ff, visible_in, last_ff, last_in;

   assign entry = entry_type'(q_data);

   always_comb begin
      fin   = u_ff >= end_ff;
      load  = 1'b0;
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            load = !q_stat.empty;
         end
         BACK_WALK: begin
            load = fin && !q_stat.empty;
         end
         default: begin
            load = 1'b0;
         end
      endcase
      if (load) begin
         state_in = BACK_WALK;
      end else if (state_ff == BACK_WALK && fin) begin
         state_in = BACK_IDLE;
      end

      u_in      = u_ff;
      minor_in  = minor_ff;
      end_in    = end_ff;
      d_in      = d_ff;
      inc_e_in  = inc_e_ff;
      inc_ne_in = inc_ne_ff;
      steep_in  = steep_ff;
      mirror_in = mirror_ff;
      if (load) begin
         u_in      = entry.u_start;
         minor_in  = entry.v_start;
         end_in    = entry.u_end;
         inc_e_in  = $signed({2'b00, entry.dy, 1'b0});
         d_in      = $signed({2'b00, entry.dy, 1'b0}) - $signed({3'b000, entry.dx});
         inc_ne_in = $signed({2'b00, entry.dy, 1'b0}) - $signed({2'b00, entry.dx, 1'b0});
         steep_in  = entry.steep;
         mirror_in = entry.mirror;
      end else if (state_ff == BACK_WALK) begin
         // Tie steps along the major axis only
         u_in = u_ff + C'(1);
         if (d_ff <= 0) begin
            d_in = d_ff + inc_e_ff;
         end else begin
            d_in     = d_ff + inc_ne_ff;
            minor_in = mirror_ff ? (minor_ff - C'(1)) : (minor_ff + C'(1));
         end
      end

      rsp_valid_in = state_ff == BACK_WALK;
      pix_x_in     = steep_ff ? minor_ff : u_ff;
      pix_y_in     = steep_ff ? u_ff : minor_ff;
      visible_in   = ({1'b0, pix_x_in} < col_limit) && ({1'b0, pix_y_in} < row_limit);
      last_in      = fin;
   end

   assign q_pop       = load;
   assign busy_walk   = state_ff == BACK_WALK;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pix_x   = pix_x_ff;
   assign rsp_pix_y   = pix_y_ff;
   assign rsp_visible = visible_ff;
   assign rsp_last    = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff       <= u_in;
      minor_ff   <= minor_in;
      end_ff     <= end_in;
      d_ff       <= d_in;
      inc_e_ff   <= inc_e_in;
      inc_ne_ff  <= inc_ne_in;
      steep_ff   <= steep_in;
      mirror_ff  <= mirror_in;
      pix_x_ff   <= pix_x_in;
      pix_y_ff   <= pix_y_in;
      visible_ff <= visible_in;
      last_ff    <= last_in;
   end

endmodule

### tb/tb_top.sv
// Self-checking bench for midpoint_line_rasterizer_core: sends line segments, predicts
// every pixel of their midpoint scan conversion and compares what comes out.
// Depends on mlr_pkg and the RTL of the core; reads and writes no files.
module tb_top;
   import mlr_pkg::*;

   localparam int CB         = COORD_BITS_DEF;
   localparam int TOP        = (1 << CB) - 1;
   localparam int QUIET_MAX  = 3000;  // cycles with no request or pixel before giving up
   localparam int SHOW_MAX   = 40;    // mismatch lines printed before going quiet
   localparam int NUM_PHASES = 7;

   typedef logic [CB-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      visible;
      logic      last;
   } pixel_type;

   typedef struct packed {
      coord_type xs;
      coord_type ys;
      coord_type xe;
      coord_type ye;
   } segment_type;

   // One row of the directed table. Where known is set, the segment is a single point and
   // its one pixel is typed in; every other row goes through the predictor.
   typedef struct packed {
      segment_type seg;
      logic        known;
      pixel_type   pix;
   } stim_row_type;

   localparam int NUM_DIRECTED = 22;
   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      // single points at the corners and on alternating bit patterns
      '{'{ 0,  0,  0,  0}, 1'b1, '{ 0,  0, 1'b1, 1'b1}},
      '{'{63, 63, 63, 63}, 1'b1, '{63, 63, 1'b1, 1'b1}},
      '{'{42, 21, 42, 21}, 1'b1, '{42, 21, 1'b1, 1'b1}},
      '{'{21, 42, 21, 42}, 1'b1, '{21, 42, 1'b1, 1'b1}},
      // full-length horizontal and vertical, both endpoint orders
      '{'{ 0,  0, 63,  0}, 1'b0, '0},
      '{'{63, 63,  0, 63}, 1'b0, '0},
      '{'{ 0,  0,  0, 63}, 1'b0, '0},
      '{'{63, 63, 63,  0}, 1'b0, '0},
      // both full diagonals, both orders
      '{'{ 0,  0, 63, 63}, 1'b0, '0},
      '{'{63, 63,  0,  0}, 1'b0, '0},
      '{'{ 0, 63, 63,  0}, 1'b0, '0},
      '{'{63,  0,  0, 63}, 1'b0, '0},
      // shallow and steep, rising and falling, reversed endpoints among them
      '{'{ 0,  0, 63, 20}, 1'b0, '0},
      '{'{63,  5,  0, 40}, 1'b0, '0},
      '{'{ 5,  0, 20, 63}, 1'b0, '0},
      '{'{40,  0, 10, 63}, 1'b0, '0},
      // midpoint ties: decision value exactly zero on the first step
      '{'{ 0,  0,  4,  2}, 1'b0, '0},
      '{'{ 4,  0,  0,  2}, 1'b0, '0},
      '{'{ 0,  0,  2,  4}, 1'b0, '0},
      // odd octants and toggling bit patterns
      '{'{42, 21, 21, 42}, 1'b0, '0},
      '{'{21, 42, 42, 60}, 1'b0, '0},
      '{'{10, 10, 12,  5}, 1'b0, '0}
   };

   // Limit settings and sender idling per random phase; a limit of -1 is drawn at random.
   // Extremes: zero hides everything, one keeps a single column or row, 127 sets every
   // data bit and shows everything.
   localparam int PHASE_COLS  [NUM_PHASES] = '{  1,  0, 127, 40, 64, -1, 64};
   localparam int PHASE_ROWS  [NUM_PHASES] = '{  1,  0, 127, 25,  1, -1, 65};
   localparam int PHASE_ITEMS [NUM_PHASES] = '{ 30, 20,  40, 50, 30, 40, 40};
   localparam int PHASE_IDLE  [NUM_PHASES] = '{ 76,  0,  30,  0, 76, 30,  0};

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   coord_type       req_x_start;
   coord_type       req_y_start;
   coord_type       req_x_end;
   coord_type       req_y_end;
   logic            csr_write_enable;
   logic [0:0]      csr_index;
   logic [CB:0]     csr_data;
   logic            rsp_valid;
   coord_type       rsp_pix_x;
   coord_type       rsp_pix_y;
   logic            rsp_visible;
   logic            rsp_last;

   // Pixels still owed by the core, oldest first, and the limits they were predicted with
   pixel_type       pending_pixels [$];
   logic [CB:0]     cols_shown;
   logic [CB:0]     rows_shown;

   int              mismatches;
   int              segments_sent;
   int              pixels_seen;
   int              visible_seen;
   int              settings_used;
   int              quiet_cycles;

   midpoint_line_rasterizer_core #(
      .COORD_BITS(CB)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_pix_x       (rsp_pix_x),
      .rsp_pix_y       (rsp_pix_y),
      .rsp_visible     (rsp_visible),
      .rsp_last        (rsp_last)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Print one line per wrong field, up to a cap, and count every one.
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= SHOW_MAX) begin
         $display("mismatch at pixel %0d: %s got %0d want %0d", pixels_seen, what, got, want);
      end
   endtask

   // Walk the segment along its major axis and queue every pixel it should produce.
   // Endpoints are ordered by column; a steep segment swaps axes and is ordered again;
   // a falling one is walked rising and reflected about its start row.
   function automatic void trace_segment(input segment_type s);
      int        ax, ay, bx, by, t, dx, dy, d, u, v, minor;
      bit        steep, mirror, fin;
      pixel_type p;
      ax = s.xs;
      ay = s.ys;
      bx = s.xe;
      by = s.ye;
      if (ax > bx) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
      end
      steep = ((by > ay) ? by - ay : ay - by) > bx - ax;
      if (steep) begin
         t = ax; ax = ay; ay = t;
         t = bx; bx = by; by = t;
         if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
         end
      end
      dx = bx - ax;
      dy = by - ay;
      mirror = dy < 0;
      if (mirror) dy = -dy;
      d = 2 * dy - dx;
      u = ax;
      v = ay;
      do begin
         minor = mirror ? 2 * ay - v : v;
         fin = u >= bx;
         if (steep) begin
            p.x = coord_type'(minor);
            p.y = coord_type'(u);
         end else begin
            p.x = coord_type'(u);
            p.y = coord_type'(minor);
         end
         p.visible = (p.x < cols_shown) && (p.y < rows_shown);
         p.last    = fin;
         pending_pixels.push_back(p);
         // a tie steps along the major axis only
         if (d <= 0) begin
            d += 2 * dy;
         end else begin
            d += 2 * (dy - dx);
            v++;
         end
         u++;
      end while (!fin);
   endfunction

   function automatic int clamp_coord(input int c);
      return (c < 0) ? 0 : (c > TOP) ? TOP : c;
   endfunction

   // Draw a segment: mostly arbitrary endpoints, plus short, axis-aligned, diagonal
   // and single-point segments so that every shape keeps turning up.
   function automatic segment_type make_segment();
      int          kind, x0, y0, x1, y1, sx, sy, reach, span;
      segment_type s;
      kind = $urandom_range(9);
      x0 = $urandom_range(TOP);
      y0 = $urandom_range(TOP);
      x1 = $urandom_range(TOP);
      y1 = $urandom_range(TOP);
      case (kind)
         5, 6: begin
            x1 = clamp_coord(x0 + int'($urandom_range(6)) - 3);
            y1 = clamp_coord(y0 + int'($urandom_range(6)) - 3);
         end
         7: begin
            if ($urandom_range(1)) y1 = y0;
            else x1 = x0;
         end
         8: begin
            sx = $urandom_range(1) ? 1 : -1;
            sy = $urandom_range(1) ? 1 : -1;
            reach = (sx > 0) ? TOP - x0 : x0;
            if (((sy > 0) ? TOP - y0 : y0) < reach) reach = (sy > 0) ? TOP - y0 : y0;
            span = $urandom_range(reach);
            x1 = x0 + sx * span;
            y1 = y0 + sy * span;
         end
         9: begin
            x1 = x0;
            y1 = y0;
         end
         default: ;
      endcase
      s.xs = coord_type'(x0);
      s.ys = coord_type'(y0);
      s.xe = coord_type'(x1);
      s.ye = coord_type'(y1);
      return s;
   endfunction

   // Present one request after a random run of idle cycles and hold it until the core
   // takes it. Start stays high afterwards so that back-to-back requests need no gap;
   // the next idle cycle or the next request decides its value at the falling edge.
   task automatic issue_segment(input segment_type s, input int idle_pct, input bit known,
                                input pixel_type pix);
      while (int'($urandom_range(99)) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start       = 1'b1;
      req_x_start = s.xs;
      req_y_start = s.ys;
      req_x_end   = s.xe;
      req_y_end   = s.ye;
      do @(posedge clock); while (busy !== 1'b0);
      if (known) pending_pixels.push_back(pix);
      else trace_segment(s);
      segments_sent++;
   endtask

   // Drop start and wait until every owed pixel has come out, then wait on so the walker
   // and the queue are surely empty.
   task automatic settle_pipeline();
      @(negedge clock);
      start = 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one limit register for a single cycle and track it in the prediction.
   task automatic write_limit(input mlr_csr_type which, input int value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = which;
      csr_data         = value[CB:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (which)
         CSR_COL_LIMIT: cols_shown = value[CB:0];
         CSR_ROW_LIMIT: rows_shown = value[CB:0];
         default: ;
      endcase
   endtask

   // Capture each pixel in the cycle it is shown: the core cannot be held off, so a
   // strobe is always a pixel. Compare it field by field with the oldest prediction.
   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_valid === 1'b1) begin
         pixels_seen++;
         if (rsp_visible === 1'b1) visible_seen++;
         if (pending_pixels.size() == 0) begin
            report_mismatch("pixel with none pending, x", rsp_pix_x, -1);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pix_x !== want.x) report_mismatch("pix_x", rsp_pix_x, want.x);
            if (rsp_pix_y !== want.y) report_mismatch("pix_y", rsp_pix_y, want.y);
            if (rsp_visible !== want.visible) begin
               report_mismatch("visible", rsp_visible, want.visible);
            end
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // Watchdog: a stretch with neither a request taken nor a pixel shown means a hang.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_MAX) begin
         $display("watchdog: nothing moved for %0d cycles, %0d pixels pending",
                  QUIET_MAX, pending_pixels.size());
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int p, n, col, row;
      reset            = 1'b1;
      start            = 1'b0;
      req_x_start      = '0;
      req_y_start      = '0;
      req_x_end        = '0;
      req_y_end        = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_COL_LIMIT;
      csr_data         = '0;
      cols_shown       = (CB + 1)'(1 << CB);
      rows_shown       = (CB + 1)'(1 << CB);
      mismatches       = 0;
      segments_sent    = 0;
      pixels_seen      = 0;
      visible_seen     = 0;
      settings_used    = 1;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table at the reset limits, no idling
      for (n = 0; n < NUM_DIRECTED; n++) begin
         issue_segment(DIRECTED[n].seg, 0, DIRECTED[n].known, DIRECTED[n].pix);
      end
      settle_pipeline();

      // Random phases, each with its own limits and sender idling; halfway through
      // each phase the sender holds off until the core has drained completely.
      for (p = 0; p < NUM_PHASES; p++) begin
         col = (PHASE_COLS[p] < 0) ? int'($urandom_range(127)) : PHASE_COLS[p];
         row = (PHASE_ROWS[p] < 0) ? int'($urandom_range(127)) : PHASE_ROWS[p];
         write_limit(CSR_COL_LIMIT, col);
         write_limit(CSR_ROW_LIMIT, row);
         settings_used++;
         for (n = 0; n < PHASE_ITEMS[p]; n++) begin
            if (n == PHASE_ITEMS[p] / 2) settle_pipeline();
            issue_segment(make_segment(), PHASE_IDLE[p], 1'b0, '0);
         end
         settle_pipeline();
      end
      repeat (8) @(posedge clock);

      $display("run covered %0d segments and %0d pixels (%0d visible)",
               segments_sent, pixels_seen, visible_seen);
      $display("over %0d limit settings with sender idling at 0, 30 and 76 percent; %0d mismatches",
               settings_used, mismatches);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
